FILE: hdl/tds_pkg.sv
package tds_pkg;

    // vector component width
    localparam int VEC_W   = 16;
    // squared magnitude and squared length
    localparam int SQ_W    = 2 * VEC_W - 1;
    localparam int LEN_W   = 2 * VEC_W;
    // divider partial remainder
    localparam int DREM_W  = LEN_W + 1;
    // quotient of |c|^2 * 2^30 / len, never above 2^30
    localparam int QUO_W   = 31;
    localparam int DIN_W   = QUO_W + 1;
    // integer root of the quotient, never above 2^15
    localparam int ROOT_W  = DIN_W / 2;
    localparam int SREM_W  = ROOT_W + 4;
    // unit component in Q1.14
    localparam int UNIT_W  = 16;
    localparam int CFG_W   = 16;
    localparam int SHADE_W = 18;
    localparam int ST_W    = 2;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // pipeline depths: magnitude, square, length, divider, root, output
    localparam int NORM_LAT  = 4 + QUO_W + ROOT_W;
    localparam int SHADE_LAT = 4;
    localparam int TOTAL_LAT = NORM_LAT + SHADE_LAT;

    // status codes
    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO_NORMAL = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO_LIGHT  = 2'd2;

    // shade modes
    localparam logic [MODE_W-1:0] MODE_DOT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HALF = 2'd2;

    // register indexes
    localparam logic [2:0] REG_DIR_X     = 3'd0;
    localparam logic [2:0] REG_DIR_Y     = 3'd1;
    localparam logic [2:0] REG_DIR_Z     = 3'd2;
    localparam logic [2:0] REG_INTENSITY = 3'd3;
    localparam logic [2:0] REG_AMBIENT   = 3'd4;
    localparam logic [2:0] REG_MODE      = 3'd5;

    typedef struct packed {
        logic signed [VEC_W-1:0] normal_x;
        logic signed [VEC_W-1:0] normal_y;
        logic signed [VEC_W-1:0] normal_z;
    } t_in;

    typedef struct packed {
        logic signed [SHADE_W-1:0] shade_value;
        logic [ST_W-1:0]           status;
    } t_out;

    typedef struct packed {
        logic                       zero;
        logic [2:0][UNIT_W-1:0]     c;
    } t_unit;

    typedef struct packed {
        logic [2:0][VEC_W-1:0]      dir;
        logic signed [CFG_W-1:0]    intensity;
        logic signed [CFG_W-1:0]    ambient;
        logic [MODE_W-1:0]          mode;
    } t_cfg;

endpackage

FILE: hdl/tds_cfg.sv
module tds_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tds_pkg::ADDR_W-1:0] paddr,
    input  logic [tds_pkg::DATA_W-1:0] pwdata,
    output logic [tds_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output tds_pkg::t_cfg             o_cfg
);
    import tds_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir[0]    <= '0;
            r_cfg.dir[1]    <= '0;
            r_cfg.dir[2]    <= VEC_W'(16384);
            r_cfg.intensity <= CFG_W'(4096);
            r_cfg.ambient   <= '0;
            r_cfg.mode      <= MODE_DOT;
        end else if (wr_en) begin
            case (idx)
                REG_DIR_X:     r_cfg.dir[0]    <= pwdata[VEC_W-1:0];
                REG_DIR_Y:     r_cfg.dir[1]    <= pwdata[VEC_W-1:0];
                REG_DIR_Z:     r_cfg.dir[2]    <= pwdata[VEC_W-1:0];
                REG_INTENSITY: r_cfg.intensity <= pwdata[CFG_W-1:0];
                REG_AMBIENT:   r_cfg.ambient   <= pwdata[CFG_W-1:0];
                REG_MODE:      r_cfg.mode      <= pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_DIR_X:     prdata = DATA_W'(r_cfg.dir[0]);
            REG_DIR_Y:     prdata = DATA_W'(r_cfg.dir[1]);
            REG_DIR_Z:     prdata = DATA_W'(r_cfg.dir[2]);
            REG_INTENSITY: prdata = DATA_W'(unsigned'(r_cfg.intensity));
            REG_AMBIENT:   prdata = DATA_W'(unsigned'(r_cfg.ambient));
            REG_MODE:      prdata = DATA_W'(r_cfg.mode);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/tds_norm.sv
module tds_norm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [2:0][tds_pkg::VEC_W-1:0]   i_vec,
    output logic                             o_valid,
    output tds_pkg::t_unit                   o_unit
);
    import tds_pkg::*;

    // magnitude stage
    logic             r_a_vld;
    logic [VEC_W-1:0] r_a_mag [3];
    logic [2:0]       r_a_neg;

    // square stage
    logic             r_b_vld;
    logic [SQ_W-1:0]  r_b_sq [3];
    logic [2:0]       r_b_neg;

    // divider stages, index 0 holds the squared length
    logic              r_d_vld  [0:QUO_W];
    logic [DREM_W-1:0] r_d_rem  [0:QUO_W][3];
    logic [QUO_W-1:0]  r_d_quo  [0:QUO_W][3];
    logic [LEN_W-1:0]  r_d_len  [0:QUO_W];
    logic [2:0]        r_d_neg  [0:QUO_W];
    logic              r_d_zero [0:QUO_W];

    // root stages
    logic              r_s_vld  [1:ROOT_W];
    logic [SREM_W-1:0] r_s_rem  [1:ROOT_W][3];
    logic [ROOT_W-1:0] r_s_root [1:ROOT_W][3];
    logic [DIN_W-1:0]  r_s_d    [1:ROOT_W][3];
    logic [2:0]        r_s_neg  [1:ROOT_W];
    logic              r_s_zero [1:ROOT_W];

    // output stage
    logic  r_o_vld;
    t_unit r_o_unit;

    logic [2*VEC_W-1:0] sq_full [3];
    logic [LEN_W-1:0]   len_sum;

    // absolute value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else          r_a_vld <= i_valid;
        for (int i = 0; i < 3; i++) begin
            r_a_neg[i] <= i_vec[i][VEC_W-1];
            r_a_mag[i] <= i_vec[i][VEC_W-1] ? (~i_vec[i] + VEC_W'(1)) : i_vec[i];
        end
    end

    // squares
    always_comb begin
        for (int i = 0; i < 3; i++) sq_full[i] = r_a_mag[i] * r_a_mag[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else          r_b_vld <= r_a_vld;
        for (int i = 0; i < 3; i++) r_b_sq[i] <= sq_full[i][SQ_W-1:0];
        r_b_neg <= r_a_neg;
    end

    // squared length
    assign len_sum = LEN_W'(r_b_sq[0]) + LEN_W'(r_b_sq[1]) + LEN_W'(r_b_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_vld[0] <= 1'b0;
        else          r_d_vld[0] <= r_b_vld;
        for (int i = 0; i < 3; i++) begin
            r_d_rem[0][i] <= DREM_W'(r_b_sq[i]);
            r_d_quo[0][i] <= '0;
        end
        r_d_len[0]  <= len_sum;
        r_d_neg[0]  <= r_b_neg;
        r_d_zero[0] <= (len_sum == '0);
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        logic [DREM_W-1:0] t   [3];
        logic [2:0]        bit_q;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                if (k == 0) t[i] = r_d_rem[k][i];
                else        t[i] = {r_d_rem[k][i][DREM_W-2:0], 1'b0};
                bit_q[i] = (t[i] >= DREM_W'(r_d_len[k]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_d_vld[k+1] <= 1'b0;
            else          r_d_vld[k+1] <= r_d_vld[k];
            for (int i = 0; i < 3; i++) begin
                r_d_rem[k+1][i] <= bit_q[i] ? (t[i] - DREM_W'(r_d_len[k])) : t[i];
                r_d_quo[k+1][i] <= {r_d_quo[k][i][QUO_W-2:0], bit_q[i]};
            end
            r_d_len[k+1]  <= r_d_len[k];
            r_d_neg[k+1]  <= r_d_neg[k];
            r_d_zero[k+1] <= r_d_zero[k];
        end
    end

    // integer square root, one root bit per stage
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        logic              src_vld;
        logic [SREM_W-1:0] src_rem  [3];
        logic [ROOT_W-1:0] src_root [3];
        logic [DIN_W-1:0]  src_d    [3];
        logic [2:0]        src_neg;
        logic              src_zero;
        logic [SREM_W-1:0] rem2     [3];
        logic [SREM_W-1:0] trial    [3];
        logic [2:0]        ge;

        if (j == 0) begin : g_first
            always_comb begin
                src_vld  = r_d_vld[QUO_W];
                src_neg  = r_d_neg[QUO_W];
                src_zero = r_d_zero[QUO_W];
                for (int i = 0; i < 3; i++) begin
                    src_rem[i]  = '0;
                    src_root[i] = '0;
                    src_d[i]    = {1'b0, r_d_quo[QUO_W][i]};
                end
            end
        end else begin : g_next
            always_comb begin
                src_vld  = r_s_vld[j];
                src_neg  = r_s_neg[j];
                src_zero = r_s_zero[j];
                for (int i = 0; i < 3; i++) begin
                    src_rem[i]  = r_s_rem[j][i];
                    src_root[i] = r_s_root[j][i];
                    src_d[i]    = r_s_d[j][i];
                end
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem2[i]  = {src_rem[i][SREM_W-3:0], src_d[i][DIN_W-1-2*j -: 2]};
                trial[i] = {2'b00, src_root[i], 2'b01};
                ge[i]    = (rem2[i] >= trial[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_s_vld[j+1] <= 1'b0;
            else          r_s_vld[j+1] <= src_vld;
            for (int i = 0; i < 3; i++) begin
                r_s_rem[j+1][i]  <= ge[i] ? (rem2[i] - trial[i]) : rem2[i];
                r_s_root[j+1][i] <= {src_root[i][ROOT_W-2:0], ge[i]};
                r_s_d[j+1][i]    <= src_d[i];
            end
            r_s_neg[j+1]  <= src_neg;
            r_s_zero[j+1] <= src_zero;
        end
    end

    // round half up and restore the sign
    logic [ROOT_W:0]   rnd [3];
    logic [UNIT_W-1:0] q   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = (ROOT_W+1)'(r_s_root[ROOT_W][i]) + (ROOT_W+1)'(1);
            q[i]   = UNIT_W'(rnd[i][ROOT_W:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else          r_o_vld <= r_s_vld[ROOT_W];
        for (int i = 0; i < 3; i++)
            r_o_unit.c[i] <= r_s_neg[ROOT_W][i] ? (~q[i] + UNIT_W'(1)) : q[i];
        r_o_unit.zero <= r_s_zero[ROOT_W];
    end

    assign o_valid = r_o_vld;
    assign o_unit  = r_o_unit;

endmodule

FILE: hdl/tds_shade.sv
module tds_shade (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tds_pkg::t_unit i_nrm,
    input  tds_pkg::t_unit i_lgt,
    input  tds_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output tds_pkg::t_out  o_result
);
    import tds_pkg::*;

    localparam int PROD_W = 2 * UNIT_W;
    localparam int DOT_W  = PROD_W + 1;
    localparam int D29_W  = DOT_W + 1;
    localparam int P_W    = 52;
    localparam int SH_W   = P_W - 29;

    logic                     r_p_vld, r_q_vld, r_r_vld, r_o_vld;
    logic signed [PROD_W-1:0] r_p_prod [3];
    logic                     r_p_zn, r_p_zl, r_q_zn, r_q_zl, r_r_zn, r_r_zl;
    logic signed [D29_W-1:0]  r_q_d29;
    logic signed [P_W-1:0]    r_r_p;
    t_out                     r_out;

    logic signed [DOT_W-1:0]     dot;
    logic signed [D29_W-1:0]     d29;
    logic signed [CFG_W+D29_W-1:0] pm;
    logic signed [P_W-1:0]       w;
    logic signed [SH_W-1:0]      sh;
    logic signed [SHADE_W-1:0]   sat;

    // component products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p_vld <= 1'b0;
        else          r_p_vld <= i_valid;
        for (int i = 0; i < 3; i++)
            r_p_prod[i] <= $signed(i_nrm.c[i]) * $signed(i_lgt.c[i]);
        r_p_zn <= i_nrm.zero;
        r_p_zl <= i_lgt.zero;
    end

    // dot product and mode offset
    always_comb begin
        dot = DOT_W'(r_p_prod[0]) + DOT_W'(r_p_prod[1]) + DOT_W'(r_p_prod[2]);
        if (i_cfg.mode == MODE_HALF) d29 = D29_W'(dot) + D29_W'(268435456);
        else                         d29 = D29_W'(dot) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_q_vld <= 1'b0;
        else          r_q_vld <= r_p_vld;
        r_q_d29 <= d29;
        r_q_zn  <= r_p_zn;
        r_q_zl  <= r_p_zl;
    end

    // intensity scaling
    assign pm = i_cfg.intensity * r_q_d29;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_r_vld <= 1'b0;
        else          r_r_vld <= r_q_vld;
        r_r_p  <= (i_cfg.mode == MODE_INV) ? -P_W'(pm) : P_W'(pm);
        r_r_zn <= r_q_zn;
        r_r_zl <= r_q_zl;
    end

    // ambient, rounding and saturation
    always_comb begin
        w  = r_r_p + (P_W'(i_cfg.ambient) <<< 29) + P_W'(268435456);
        sh = w[P_W-1:29];
        if (sh > SH_W'(131071))       sat = SHADE_W'(131071);
        else if (sh < -SH_W'(131072)) sat = -SHADE_W'(131072);
        else                          sat = sh[SHADE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else          r_o_vld <= r_r_vld;
        if (r_r_zn) begin
            r_out.shade_value <= '0;
            r_out.status      <= ST_ZERO_NORMAL;
        end else if (r_r_zl) begin
            r_out.shade_value <= '0;
            r_out.status      <= ST_ZERO_LIGHT;
        end else begin
            r_out.shade_value <= sat;
            r_out.status      <= ST_OK;
        end
    end

    assign o_valid  = r_o_vld;
    assign o_result = r_out;

endmodule

FILE: hdl/toon_diffuse_shade_core.sv
// Diffuse shade engine: a new normal can be started every clock cycle and
// o_busy never rises. Each transaction's result appears on o_result with
// o_valid high for one cycle, after the normal and the light direction are
// normalized and the dot product, mode and saturation stages have run;
// results leave in start order. The pipeline depth is set by the
// 31-step restoring divider and 16-step square root in each component lane.
// The light registers may only be written while no transaction is in flight.
module toon_diffuse_shade_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  tds_pkg::t_in                i_item,
    output logic                        o_valid,
    output tds_pkg::t_out               o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tds_pkg::ADDR_W-1:0]  paddr,
    input  logic [tds_pkg::DATA_W-1:0]  pwdata,
    output logic [tds_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import tds_pkg::*;

    t_cfg                  cfg;
    t_unit                 nrm_unit, lgt_unit;
    logic                  nrm_vld, lgt_vld;
    logic                  accept;
    logic [2:0][VEC_W-1:0] nrm_vec;

    assign o_busy  = 1'b0;
    assign accept  = i_start && !o_busy;
    assign nrm_vec = {i_item.normal_z, i_item.normal_y, i_item.normal_x};

    // configuration registers
    tds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // normal vector normalization
    tds_norm u_norm_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_vec   (nrm_vec),
        .o_valid (nrm_vld),
        .o_unit  (nrm_unit)
    );

    // light direction normalization, runs alongside each transaction
    tds_norm u_norm_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_vec   (cfg.dir),
        .o_valid (lgt_vld),
        .o_unit  (lgt_unit)
    );

    // dot product and shading
    tds_shade u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (nrm_vld && lgt_vld),
        .i_nrm    (nrm_unit),
        .i_lgt    (lgt_unit),
        .i_cfg    (cfg),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // a result only follows a start at the full pipeline depth
    a_result_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, TOTAL_LAT))
        else $error("result without matching start");

    // error statuses carry a zero shade
    a_error_zero_shade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |-> (o_result.shade_value == '0))
        else $error("nonzero shade with error status");

    // both normalizer lanes stay in step
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nrm_vld == lgt_vld)
        else $error("normalizer lanes out of step");

endmodule
